/* design/jeig_pkg.sv */
// shared types, constants and tables for the jacobi eigen solver
package jeig_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_PREP,
        ST_ANGLE,
        ST_NDOWN,
        ST_NUP,
        ST_VEC,
        ST_ROT,
        ST_MUL,
        ST_PAIR,
        ST_PAIRQ,
        ST_GATHER,
        ST_OUT
    } t_state;

    // big operand select of the shared multiplier
    typedef enum logic [2:0] {
        A_C, A_S, A_AII, A_AJJ, A_AIJ, A_DIF, A_P, A_Q
    } t_asel;

    // coefficient select of the shared multiplier
    typedef enum logic [2:0] {
        B_C, B_S, B_CC, B_SS, B_SC, B_SC2, B_CMSS
    } t_bsel;

    // how a product joins the running sum
    typedef enum logic [1:0] {
        M_LOAD, M_ADD, M_SUB
    } t_mode;

    // where the running sum goes when an op finishes
    typedef enum logic [3:0] {
        D_NONE, D_CC, D_SS, D_SC, D_AII, D_AJJ, D_AIJ, D_P, D_Q
    } t_dest;

    // one micro-op of the rotation program
    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        t_mode mode;
        t_dest dest;
    } t_uop;

    // configuration register indexes
    localparam logic [1:0] CFG_VECTORS = 2'd0;
    localparam logic [1:0] CFG_MAX_ROT = 2'd1;
    localparam logic [1:0] CFG_TOL     = 2'd2;

    localparam logic [3:0] SCAN_LAST     = 4'd9;
    localparam logic [3:0] SCAN_UPPER    = 4'd6;
    localparam logic [3:0] OP_PAIR_FIRST = 4'd11;

    localparam logic signed [63:0] CORDIC_X0 = 64'sh0000_0000_26DD_3B6A;
    localparam logic signed [31:0] Q30_ONE   = 32'sh4000_0000;
    localparam logic signed [63:0] NORM_HI   = 64'sh0800_0000_0000_0000;
    localparam logic signed [63:0] NORM_LO   = 64'sh0400_0000_0000_0000;

    // atan(2^-k) in Q2.30
    function automatic logic [31:0] atan_val(input logic [4:0] k);
        logic [31:0] t;
        case (k)
            5'd0:  t = 32'h3243F6A8;
            5'd1:  t = 32'h1DAC6705;
            5'd2:  t = 32'h0FADBAFC;
            5'd3:  t = 32'h07F56EA6;
            5'd4:  t = 32'h03FEAB76;
            5'd5:  t = 32'h01FFD55B;
            5'd6:  t = 32'h00FFFAAA;
            5'd7:  t = 32'h007FFF55;
            5'd8:  t = 32'h003FFFEA;
            5'd9:  t = 32'h001FFFFD;
            5'd10: t = 32'h000FFFFF;
            5'd11: t = 32'h0007FFFF;
            5'd12: t = 32'h0003FFFF;
            5'd13: t = 32'h0001FFFF;
            5'd14: t = 32'h0000FFFF;
            5'd15: t = 32'h00007FFF;
            5'd16: t = 32'h00003FFF;
            5'd17: t = 32'h00001FFF;
            5'd18: t = 32'h00000FFF;
            5'd19: t = 32'h000007FF;
            5'd20: t = 32'h000003FF;
            5'd21: t = 32'h000001FF;
            5'd22: t = 32'h000000FF;
            5'd23: t = 32'h0000007F;
            5'd24: t = 32'h0000003F;
            5'd25: t = 32'h0000001F;
            5'd26: t = 32'h0000000F;
            5'd27: t = 32'h00000008;
            5'd28: t = 32'h00000004;
            5'd29: t = 32'h00000002;
            5'd30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

    // scan order: upper pairs row-major, then the diagonal
    function automatic logic [3:0] scan_addr(input logic [3:0] idx);
        logic [3:0] a;
        case (idx)
            4'd0: a = 4'd1;
            4'd1: a = 4'd2;
            4'd2: a = 4'd3;
            4'd3: a = 4'd6;
            4'd4: a = 4'd7;
            4'd5: a = 4'd11;
            4'd6: a = 4'd0;
            4'd7: a = 4'd5;
            4'd8: a = 4'd10;
            default: a = 4'd15;
        endcase
        return a;
    endfunction

    // rotation program: coefficients, diagonal block, then one pair update
    function automatic t_uop uop_decode(input logic [3:0] op);
        t_uop u;
        case (op)
            4'd0:  u = '{A_C,   B_C,    M_LOAD, D_CC};
            4'd1:  u = '{A_S,   B_S,    M_LOAD, D_SS};
            4'd2:  u = '{A_S,   B_C,    M_LOAD, D_SC};
            4'd3:  u = '{A_AII, B_CC,   M_LOAD, D_NONE};
            4'd4:  u = '{A_AIJ, B_SC2,  M_SUB,  D_NONE};
            4'd5:  u = '{A_AJJ, B_SS,   M_ADD,  D_AII};
            4'd6:  u = '{A_AII, B_SS,   M_LOAD, D_NONE};
            4'd7:  u = '{A_AIJ, B_SC2,  M_ADD,  D_NONE};
            4'd8:  u = '{A_AJJ, B_CC,   M_ADD,  D_AJJ};
            4'd9:  u = '{A_AIJ, B_CMSS, M_LOAD, D_NONE};
            4'd10: u = '{A_DIF, B_SC,   M_ADD,  D_AIJ};
            4'd11: u = '{A_P,   B_C,    M_LOAD, D_NONE};
            4'd12: u = '{A_Q,   B_S,    M_SUB,  D_P};
            4'd13: u = '{A_P,   B_S,    M_LOAD, D_NONE};
            4'd14: u = '{A_Q,   B_C,    M_ADD,  D_Q};
            default: u = '{A_C, B_C,    M_LOAD, D_NONE};
        endcase
        return u;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] fit32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

/* design/jacobi_eigen_4x4_symmetric_core.sv */
// jacobi eigen solver for a symmetric 4x4 matrix, sequenced over one shared datapath
//
// Load the matrix one entry a word (row, col, Q16.16 value); the word with last set
// starts the solve, and stall stays high until the fourth result word has been taken.
// Each rotation runs a pivot scan over ten entries, a fetch of the three pivot
// operands, angle normalization by single-bit shifts, a vectoring and a rotation
// CORDIC pass of CORDIC_STEPS steps each (equal diagonals go straight to rotation),
// then 11 coefficient and diagonal products plus up to 6 row/vector pair updates of
// 4 products each, every product on one 32x32 multiplier; with eigenvectors off the
// vector pair updates are skipped. When the solve ends, each of the four result
// words is gathered one field at a time.
module jacobi_eigen_4x4_symmetric_core
    import jeig_pkg::*;
#(
    parameter int INTERNAL_WIDTH = 48,
    parameter int CORDIC_STEPS   = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_row,
    input  logic [1:0]         i_col,
    input  logic signed [31:0] i_entry_value,
    input  logic               i_last,
    // result words
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_eig_index,
    output logic signed [31:0] o_eigenvalue,
    output logic signed [31:0] o_vec_0,
    output logic signed [31:0] o_vec_1,
    output logic signed [31:0] o_vec_2,
    output logic signed [31:0] o_vec_3,
    output logic [7:0]         o_rotations_used,
    output logic               o_converged,
    output logic               o_last_result,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    localparam int W     = INTERNAL_WIDTH;
    localparam int GUARD = INTERNAL_WIDTH - 40;
    localparam int CW    = 35;
    localparam logic [4:0] K_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic signed [63:0] W_HI =
        $signed(64'h7FFF_FFFF_FFFF_FFFF >> (64 - INTERNAL_WIDTH));
    localparam logic signed [63:0] W_LO = ~W_HI;
    localparam logic signed [64:0] EV_HALF = 65'((64'd1 << GUARD) >> 1);
    localparam logic [96:0] MUL_RND = {67'd0, 1'b1, 29'd0};

    // clamp to the internal width
    function automatic logic signed [W-1:0] fitw(input logic signed [63:0] v);
        if (v > W_HI) begin
            return W_HI[W-1:0];
        end
        if (v < W_LO) begin
            return W_LO[W-1:0];
        end
        return v[W-1:0];
    endfunction

    // round away the guard bits and clamp to 32 bits
    function automatic logic signed [31:0] round_ev(input logic signed [W-1:0] a);
        logic signed [64:0] s;
        logic signed [63:0] c;
        s = 65'(a) + EV_HALF;
        if (s[64] != s[63]) begin
            c = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            c = s[63:0];
        end
        return fit32(c >>> GUARD);
    endfunction

    function automatic logic over_mag(input logic signed [63:0] v,
                                      input logic signed [63:0] lim);
        return (v >= lim) || (v <= -lim);
    endfunction

    // state and storage
    t_state r_state, n_state;
    logic              r_cv;
    logic [7:0]        r_max_rot;
    logic [5:0]        r_tol;
    logic signed [W-1:0] r_a [16];
    logic signed [31:0]  r_v [16];
    logic [7:0]        r_rot;
    logic              r_conv;
    logic [3:0]        r_scan;
    logic [W-1:0]      r_off, r_dmax;
    logic [1:0]        r_pi, r_pj;
    logic [1:0]        r_sub;
    logic signed [W-1:0] r_aii, r_ajj, r_aij;
    logic signed [63:0]  r_dif;
    logic signed [63:0]  r_x, r_y;
    logic signed [33:0]  r_z;
    logic [4:0]        r_k;
    logic signed [CW-1:0] r_c, r_s, r_cc, r_ss, r_sc, r_sc2, r_cmss;
    logic [3:0]        r_pair;
    logic signed [63:0]  r_p, r_q;
    logic [3:0]        r_op;
    logic [1:0]        r_mph;
    logic [63:0]       r_prod;
    logic [96:0]       r_acc;
    logic signed [63:0]  r_sum;
    logic [1:0]        r_gk;
    logic [2:0]        r_gsub;
    logic              r_ovalid;
    logic signed [31:0]  r_oev;
    logic signed [31:0]  r_ovec [4];

    // handshake
    logic in_acc, out_acc;
    assign o_stall = (r_state != ST_LOAD);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;

    // single read port of each array
    logic [3:0] a_addr, v_addr;
    logic [1:0] pk;
    logic       pvec;
    logic signed [W-1:0] rd_a;
    logic signed [31:0]  rd_v;
    logic [W-1:0]        rd_mag;
    assign pk   = r_pair[1:0];
    assign pvec = !r_pair[2];

    always_comb begin
        a_addr = 4'd0;
        v_addr = 4'd0;
        case (r_state)
            ST_SCAN: a_addr = scan_addr(r_scan);
            ST_PREP: begin
                case (r_sub)
                    2'd0: a_addr = {r_pi, r_pi};
                    2'd1: a_addr = {r_pj, r_pj};
                    default: a_addr = {r_pi, r_pj};
                endcase
            end
            ST_PAIR: begin
                a_addr = {r_pi, pk};
                v_addr = {pk, r_pi};
            end
            ST_PAIRQ: begin
                a_addr = {r_pj, pk};
                v_addr = {pk, r_pj};
            end
            ST_GATHER: begin
                a_addr = {r_gk, r_gk};
                v_addr = {2'(r_gsub - 3'd1), r_gk};
            end
            default: begin
                a_addr = 4'd0;
                v_addr = 4'd0;
            end
        endcase
    end

    assign rd_a   = r_a[a_addr];
    assign rd_v   = r_v[v_addr];
    assign rd_mag = W'(mag64(64'(rd_a)));

    // scan and decision
    logic stop_now, conv_now;
    assign conv_now = r_off <= (r_dmax >> r_tol);
    assign stop_now = conv_now || (r_rot >= r_max_rot);

    // shared cordic step
    logic signed [63:0] xs, ys, x_step, y_step;
    logic signed [33:0] tab, z_step;
    logic               plus;
    assign xs   = r_x >>> r_k;
    assign ys   = r_y >>> r_k;
    assign tab  = 34'(atan_val(r_k));
    assign plus = (r_state == ST_VEC) ? !r_y[63] : r_z[33];
    assign x_step = plus ? (r_x + ys) : (r_x - ys);
    assign y_step = plus ? (r_y - xs) : (r_y + xs);
    assign z_step = plus ? (r_z + tab) : (r_z - tab);

    // angle setup
    logic signed [63:0] s_aii, s_ajj, s_aij;
    logic               norm_big, norm_grow;
    assign s_aii = 64'(r_aii);
    assign s_ajj = 64'(r_ajj);
    assign s_aij = 64'(r_aij);
    assign norm_big  = over_mag(r_x, NORM_HI) || over_mag(r_y, NORM_HI);
    assign norm_grow = ((r_x | r_y) != 64'd0) && !over_mag(r_x, NORM_LO)
                       && !over_mag(r_y, NORM_LO);

    // shared multiplier operands
    t_uop               uop;
    logic signed [63:0] opa;
    logic signed [CW-1:0] opb;
    logic [63:0]        ua;
    logic [31:0]        ub;
    logic [CW-1:0]      ub_full;
    logic               mneg;
    assign uop = uop_decode(r_op);

    always_comb begin
        case (uop.asel)
            A_C:   opa = 64'(r_c);
            A_S:   opa = 64'(r_s);
            A_AII: opa = s_aii;
            A_AJJ: opa = s_ajj;
            A_AIJ: opa = s_aij;
            A_DIF: opa = r_dif;
            A_P:   opa = r_p;
            A_Q:   opa = r_q;
            default: opa = 64'sd0;
        endcase
        case (uop.bsel)
            B_C:    opb = r_c;
            B_S:    opb = r_s;
            B_CC:   opb = r_cc;
            B_SS:   opb = r_ss;
            B_SC:   opb = r_sc;
            B_SC2:  opb = r_sc2;
            B_CMSS: opb = r_cmss;
            default: opb = '0;
        endcase
    end

    assign ua      = mag64(opa);
    assign ub_full = opb[CW-1] ? (~opb + CW'(1)) : opb;
    assign ub      = ub_full[31:0];
    assign mneg    = opa[63] ^ opb[CW-1];

    // rounded, saturated product and its join to the running sum
    logic [66:0]        mq_mag;
    logic               mq_big;
    logic signed [63:0] mq, nsum;
    logic               grp_end;
    assign mq_mag = r_acc[96:30];
    assign mq_big = |mq_mag[66:63];
    always_comb begin
        if (mneg) begin
            mq = mq_big ? {1'b1, 63'd0} : -$signed(mq_mag[63:0]);
        end else begin
            mq = mq_big ? {1'b0, {63{1'b1}}} : $signed(mq_mag[63:0]);
        end
        case (uop.mode)
            M_ADD: nsum = sat_add64(r_sum, mq);
            M_SUB: nsum = sat_sub64(r_sum, mq);
            default: nsum = mq;
        endcase
    end
    assign grp_end = (uop.dest == D_AIJ) || (uop.dest == D_Q);

    // pair activity
    logic pair_act;
    assign pair_act = pvec ? r_cv : ((pk != r_pi) && (pk != r_pj));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:   if (in_acc && i_last) n_state = ST_SCAN;
            ST_SCAN:   if (r_scan == SCAN_LAST) n_state = ST_DECIDE;
            ST_DECIDE: n_state = stop_now ? ST_GATHER : ST_PREP;
            ST_PREP:   if (r_sub == 2'd2) n_state = ST_ANGLE;
            ST_ANGLE:  n_state = (r_aii == r_ajj) ? ST_ROT : ST_NDOWN;
            ST_NDOWN:  if (!norm_big) n_state = ST_NUP;
            ST_NUP:    if (!norm_grow) n_state = ST_VEC;
            ST_VEC:    if (r_k == K_LAST) n_state = ST_ROT;
            ST_ROT:    if (r_k == K_LAST) n_state = ST_MUL;
            ST_MUL:    if (r_mph == 2'd3 && grp_end) n_state = ST_PAIR;
            ST_PAIR: begin
                if (r_pair[3]) begin
                    n_state = ST_SCAN;
                end else if (pair_act) begin
                    n_state = ST_PAIRQ;
                end
            end
            ST_PAIRQ:  n_state = ST_MUL;
            ST_GATHER: if (r_gsub == 3'd4) n_state = ST_OUT;
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = (r_gk == 2'd3) ? ST_LOAD : ST_GATHER;
                end
            end
            default:   n_state = ST_LOAD;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv      <= 1'b1;
            r_max_rot <= 8'd100;
            r_tol     <= 6'd26;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VECTORS: r_cv      <= i_cfg_data[0];
                CFG_MAX_ROT: r_max_rot <= i_cfg_data;
                CFG_TOL:     r_tol     <= i_cfg_data[5:0];
                default:     r_cv      <= r_cv;
            endcase
        end
    end

    // control counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_rot    <= 8'd0;
            r_scan   <= 4'd0;
            r_sub    <= 2'd0;
            r_k      <= 5'd0;
            r_op     <= 4'd0;
            r_mph    <= 2'd0;
            r_pair   <= 4'd0;
            r_gk     <= 2'd0;
            r_gsub   <= 3'd0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    r_rot  <= 8'd0;
                    r_scan <= 4'd0;
                end
                ST_SCAN:   r_scan <= r_scan + 4'd1;
                ST_DECIDE: begin
                    r_sub  <= 2'd0;
                    r_gk   <= 2'd0;
                    r_gsub <= 3'd0;
                end
                ST_PREP:   r_sub <= r_sub + 2'd1;
                ST_ANGLE:  r_k <= 5'd0;
                ST_NUP:    r_k <= 5'd0;
                ST_VEC:    r_k <= (r_k == K_LAST) ? 5'd0 : r_k + 5'd1;
                ST_ROT: begin
                    r_k   <= (r_k == K_LAST) ? 5'd0 : r_k + 5'd1;
                    r_op  <= 4'd0;
                    r_mph <= 2'd0;
                end
                ST_MUL: begin
                    r_mph <= r_mph + 2'd1;
                    if (r_mph == 2'd3) begin
                        if (uop.dest == D_AIJ) begin
                            r_pair <= 4'd0;
                        end else if (uop.dest == D_Q) begin
                            r_pair <= r_pair + 4'd1;
                        end else begin
                            r_op <= r_op + 4'd1;
                        end
                    end
                end
                ST_PAIR: begin
                    if (r_pair[3]) begin
                        r_rot  <= r_rot + 8'd1;
                        r_scan <= 4'd0;
                    end else if (!pair_act) begin
                        r_pair <= r_pair + 4'd1;
                    end
                end
                ST_PAIRQ: begin
                    r_op  <= OP_PAIR_FIRST;
                    r_mph <= 2'd0;
                end
                ST_GATHER: begin
                    r_gsub <= r_gsub + 3'd1;
                    if (r_gsub == 3'd4) begin
                        r_ovalid <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_ovalid <= 1'b0;
                        r_gk     <= r_gk + 2'd1;
                        r_gsub   <= 3'd0;
                    end
                end
                default: r_ovalid <= r_ovalid;
            endcase
        end
    end

    // work matrix: loaded, rotated in place, cleared after the results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < 16; e++) begin
                r_a[e] <= '0;
            end
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        r_a[{i_row, i_col}] <= W'(64'(i_entry_value) <<< GUARD);
                    end
                end
                ST_MUL: begin
                    if (r_mph == 2'd3) begin
                        case (uop.dest)
                            D_AII: r_a[{r_pi, r_pi}] <= fitw(nsum);
                            D_AJJ: r_a[{r_pj, r_pj}] <= fitw(nsum);
                            D_AIJ: begin
                                r_a[{r_pi, r_pj}] <= fitw(nsum);
                                r_a[{r_pj, r_pi}] <= fitw(nsum);
                            end
                            D_P: begin
                                if (!pvec) begin
                                    r_a[{r_pi, pk}] <= fitw(nsum);
                                    r_a[{pk, r_pi}] <= fitw(nsum);
                                end
                            end
                            D_Q: begin
                                if (!pvec) begin
                                    r_a[{r_pj, pk}] <= fitw(nsum);
                                    r_a[{pk, r_pj}] <= fitw(nsum);
                                end
                            end
                            default: r_a[0] <= r_a[0];
                        endcase
                    end
                end
                ST_OUT: begin
                    if (out_acc && r_gk == 2'd3) begin
                        for (int e = 0; e < 16; e++) begin
                            r_a[e] <= '0;
                        end
                    end
                end
                default: r_a[0] <= r_a[0];
            endcase
        end
    end

    // eigenvector matrix: identity at solve start, rotated by column pairs
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && in_acc && i_last) begin
            for (int e = 0; e < 16; e++) begin
                r_v[e] <= (e % 5 == 0) ? Q30_ONE : 32'sd0;
            end
        end else if (r_state == ST_MUL && r_mph == 2'd3 && pvec) begin
            if (uop.dest == D_P) begin
                r_v[{pk, r_pi}] <= fit32(nsum);
            end else if (uop.dest == D_Q) begin
                r_v[{pk, r_pj}] <= fit32(nsum);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                r_off  <= '0;
                r_dmax <= '0;
                r_pi   <= 2'd0;
                r_pj   <= 2'd1;
            end
            // pivot and largest diagonal, one entry a cycle
            ST_SCAN: begin
                if (r_scan < SCAN_UPPER) begin
                    if (r_off < rd_mag) begin
                        r_off <= rd_mag;
                        r_pi  <= a_addr[3:2];
                        r_pj  <= a_addr[1:0];
                    end
                end else if (r_dmax < rd_mag) begin
                    r_dmax <= rd_mag;
                end
            end
            ST_DECIDE: r_conv <= conv_now;
            ST_PREP: begin
                case (r_sub)
                    2'd0: r_aii <= rd_a;
                    2'd1: r_ajj <= rd_a;
                    default: r_aij <= rd_a;
                endcase
            end
            // equal diagonals take the angle pi/4 directly
            ST_ANGLE: begin
                r_dif <= sat_sub64(s_aii, s_ajj);
                if (r_aii == r_ajj) begin
                    r_z <= tab;
                    r_x <= CORDIC_X0;
                    r_y <= 64'sd0;
                end else begin
                    r_x <= sat_sub64(s_ajj, s_aii);
                    r_y <= sat_add64(s_aij, s_aij);
                end
            end
            // scale down into range, then fold x positive
            ST_NDOWN: begin
                if (norm_big) begin
                    r_x <= r_x >>> 1;
                    r_y <= r_y >>> 1;
                end else if (r_x[63]) begin
                    r_x <= -r_x;
                    r_y <= -r_y;
                end
            end
            ST_NUP: begin
                r_z <= '0;
                if (norm_grow) begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
            end
            // vectoring pass: full angle, halved at the end
            ST_VEC: begin
                if (r_k == K_LAST) begin
                    r_z <= z_step >>> 1;
                    r_x <= CORDIC_X0;
                    r_y <= 64'sd0;
                end else begin
                    r_x <= x_step;
                    r_y <= y_step;
                    r_z <= z_step;
                end
            end
            // rotation pass: cos and sin of the half angle
            ST_ROT: begin
                r_x <= x_step;
                r_y <= y_step;
                r_z <= z_step;
                if (r_k == K_LAST) begin
                    r_c <= x_step[CW-1:0];
                    r_s <= y_step[CW-1:0];
                end
            end
            // 64 by 32 product in two halves, then round and join the sum
            ST_MUL: begin
                case (r_mph)
                    2'd0: r_prod <= 64'(ua[31:0] * ub);
                    2'd1: begin
                        r_acc  <= 97'(r_prod);
                        r_prod <= 64'(ua[63:32] * ub);
                    end
                    2'd2: r_acc <= r_acc + {1'b0, r_prod, 32'd0} + MUL_RND;
                    default: begin
                        r_sum <= nsum;
                        case (uop.dest)
                            D_CC: r_cc <= nsum[CW-1:0];
                            D_SS: r_ss <= nsum[CW-1:0];
                            D_SC: begin
                                r_sc   <= nsum[CW-1:0];
                                r_sc2  <= {nsum[CW-2:0], 1'b0};
                                r_cmss <= r_cc - r_ss;
                            end
                            default: r_cmss <= r_cmss;
                        endcase
                    end
                endcase
            end
            // first row of the pair; a finished rotation restarts the pivot search
            ST_PAIR: begin
                r_p <= pvec ? 64'(rd_v) : 64'(rd_a);
                if (r_pair[3]) begin
                    r_off  <= '0;
                    r_dmax <= '0;
                    r_pi   <= 2'd0;
                    r_pj   <= 2'd1;
                end
            end
            ST_PAIRQ: r_q <= pvec ? 64'(rd_v) : 64'(rd_a);
            // result word, one field a cycle
            ST_GATHER: begin
                if (r_gsub == 3'd0) begin
                    r_oev <= round_ev(rd_a);
                end else if (r_gsub != 3'd5 && r_gsub != 3'd6 && r_gsub != 3'd7) begin
                    r_ovec[2'(r_gsub - 3'd1)] <= r_cv ? rd_v : 32'sd0;
                end
            end
            default: r_sum <= r_sum;
        endcase
    end

    // result ports
    assign o_valid          = r_ovalid;
    assign o_eig_index      = r_gk;
    assign o_eigenvalue     = r_oev;
    assign o_vec_0          = r_ovec[0];
    assign o_vec_1          = r_ovec[1];
    assign o_vec_2          = r_ovec[2];
    assign o_vec_3          = r_ovec[3];
    assign o_rotations_used = r_rot;
    assign o_converged      = r_conv;
    assign o_last_result    = (r_gk == 2'd3);

endmodule

/* test/jacobi_eigen_4x4_symmetric_core_tb.sv */
// self-checking testbench for the 4x4 jacobi eigen solver core
`timescale 1ns / 1ps

module jacobi_eigen_4x4_symmetric_core_tb;
    import jeig_pkg::*;

    localparam int    CLK_HALF   = 6;
    localparam int    GUARD      = 8;
    localparam int    CORDIC_N   = 24;
    localparam int    HOLD_LEN   = 3000;
    localparam int    WDOG_LIMIT = 300000;
    localparam int    DIR_N      = 21;
    localparam longint W_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint W_MIN     = -64'sh0000_8000_0000_0000;
    localparam longint L_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint L_MIN     = 64'sh8000_0000_0000_0000;
    localparam longint ONE_Q30   = 64'sh4000_0000;
    localparam longint GAIN_INV  = 64'sh26DD_3B6A;

    localparam longint ATAN_Q30 [32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    // one result word
    typedef struct {
        logic [1:0]         idx;
        logic signed [31:0] eig;
        logic signed [31:0] vec [4];
        logic [7:0]         rots;
        logic               conv;
        logic               fin;
    } t_eig_word;

    // one directed input word, with a typed-in answer for diagonal loads
    typedef struct {
        logic [1:0]         r;
        logic [1:0]         c;
        logic signed [31:0] v;
        logic               lst;
        logic               typed;
        logic signed [31:0] ev [4];
    } t_dir_word;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_row;
    logic [1:0]         i_col;
    logic signed [31:0] i_entry_value;
    logic               i_last;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_eig_index;
    logic signed [31:0] o_eigenvalue;
    logic signed [31:0] o_vec_0;
    logic signed [31:0] o_vec_1;
    logic signed [31:0] o_vec_2;
    logic signed [31:0] o_vec_3;
    logic [7:0]         o_rotations_used;
    logic               o_converged;
    logic               o_last_result;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [7:0]         i_cfg_data;

    // predictor state
    longint    work_m [16];
    longint    vect_m [16];
    bit        want_vec;
    int        rot_limit;
    int        tol_sh;
    t_eig_word eig_q [$];
    int        errors;
    int        idle_cycles;
    int        burst_left;
    bit        hold_req;
    t_dir_word dir_tab [DIR_N];

    jacobi_eigen_4x4_symmetric_core i_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic logic [63:0] umag(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) return s[64] ? L_MIN : L_MAX;
        return s[63:0];
    endfunction

    function automatic longint sub_sat(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s[64] != s[63]) return s[64] ? L_MIN : L_MAX;
        return s[63:0];
    endfunction

    function automatic longint clip_w(longint v);
        return v > W_MAX ? W_MAX : (v < W_MIN ? W_MIN : v);
    endfunction

    function automatic longint clip_32(longint v);
        return v > 64'sh7FFF_FFFF ? 64'sh7FFF_FFFF :
               (v < -64'sh8000_0000 ? -64'sh8000_0000 : v);
    endfunction

    // (a*b) >> 30, magnitude rounded half up, saturated
    function automatic longint mul_q30(longint a, longint b);
        logic [127:0] p;
        logic [63:0]  r;
        bit           neg;
        neg = (a < 0) != (b < 0);
        p = {64'd0, umag(a)} * {64'd0, umag(b)};
        p = p + (128'd1 << 29);
        if (p[127:94] != 0) return neg ? L_MIN : L_MAX;
        r = p[93:30];
        if (neg) return r[63] ? L_MIN : -longint'(r);
        return r[63] ? L_MAX : longint'(r);
    endfunction

    // vectoring cordic on the normalized pair, halved
    function automatic longint half_theta(longint aii, longint ajj, longint aij);
        longint x, y, z, xs, ys;
        x = sub_sat(ajj, aii);
        y = add_sat(aij, aij);
        z = 0;
        while (umag(x) >= (64'd1 << 59) || umag(y) >= (64'd1 << 59)) begin
            x = x >>> 1;
            y = y >>> 1;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
        end
        while ((x | y) != 0 && umag(x) < (64'd1 << 58) && umag(y) < (64'd1 << 58)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int k = 0; k < CORDIC_N; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_Q30[k];
            end else begin
                x -= ys; y += xs; z -= ATAN_Q30[k];
            end
        end
        return z >>> 1;
    endfunction

    // one jacobi rotation on pivot (i, j)
    task automatic rotate_pivot(int i, int j);
        longint sv [16];
        longint th, s, c, cc, ss, sc, sc2, aii, ajj, aij, x, y, z, xs, ys, eki, ekj;
        sv = work_m;
        aii = sv[5*i];
        ajj = sv[5*j];
        aij = sv[4*i+j];
        th = (aii == ajj) ? ATAN_Q30[0] : half_theta(aii, ajj, aij);
        x = GAIN_INV; y = 0; z = th;
        for (int k = 0; k < CORDIC_N; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_Q30[k];
            end else begin
                x += ys; y -= xs; z += ATAN_Q30[k];
            end
        end
        c = x;
        s = y;
        cc = mul_q30(c, c);
        ss = mul_q30(s, s);
        sc = mul_q30(s, c);
        sc2 = add_sat(sc, sc);
        work_m[5*i] = clip_w(add_sat(sub_sat(mul_q30(cc, aii), mul_q30(sc2, aij)),
                                     mul_q30(ss, ajj)));
        work_m[5*j] = clip_w(add_sat(add_sat(mul_q30(ss, aii), mul_q30(sc2, aij)),
                                     mul_q30(cc, ajj)));
        work_m[4*i+j] = clip_w(add_sat(mul_q30(cc - ss, aij),
                                       mul_q30(sc, sub_sat(aii, ajj))));
        work_m[4*j+i] = work_m[4*i+j];
        for (int k = 0; k < 4; k++) begin
            if (want_vec) begin
                eki = vect_m[4*k+i];
                ekj = vect_m[4*k+j];
                vect_m[4*k+i] = clip_32(sub_sat(mul_q30(c, eki), mul_q30(s, ekj)));
                vect_m[4*k+j] = clip_32(add_sat(mul_q30(s, eki), mul_q30(c, ekj)));
            end
            if (k != i && k != j) begin
                work_m[4*i+k] = clip_w(sub_sat(mul_q30(c, sv[4*i+k]), mul_q30(s, sv[4*j+k])));
                work_m[4*k+i] = work_m[4*i+k];
                work_m[4*j+k] = clip_w(add_sat(mul_q30(s, sv[4*i+k]), mul_q30(c, sv[4*j+k])));
                work_m[4*k+j] = work_m[4*j+k];
            end
        end
    endtask

    // store one entry; on last, solve and return the four eigen words
    task automatic jacobi_solve(logic [1:0] r, logic [1:0] c, logic signed [31:0] v,
                                logic lst, output t_eig_word res [4]);
        int        pi, pj, rots;
        logic [63:0] off, dmax;
        bit        conv;
        longint    ev;
        work_m[r*4+c] = clip_w(longint'(v) * 256);
        if (!lst) return;
        for (int k = 0; k < 16; k++) vect_m[k] = (k % 5 == 0) ? ONE_Q30 : 0;
        rots = 0;
        forever begin
            pi = 0; pj = 1;
            off = umag(work_m[1]);
            dmax = 0;
            for (int a = 0; a < 4; a++) begin
                for (int b = a + 1; b < 4; b++) begin
                    if (off < umag(work_m[4*a+b])) begin
                        off = umag(work_m[4*a+b]); pi = a; pj = b;
                    end
                end
            end
            for (int a = 0; a < 4; a++) begin
                if (dmax < umag(work_m[5*a])) dmax = umag(work_m[5*a]);
            end
            conv = off <= (dmax >> tol_sh);
            if (conv || rots >= rot_limit) break;
            rotate_pivot(pi, pj);
            rots++;
        end
        for (int k = 0; k < 4; k++) begin
            ev = add_sat(work_m[5*k], 64'sd128);
            res[k].idx  = 2'(k);
            res[k].eig  = 32'(clip_32(ev >>> GUARD));
            for (int q = 0; q < 4; q++) res[k].vec[q] = want_vec ? vect_m[4*q+k][31:0] : 0;
            res[k].rots = 8'(rots);
            res[k].conv = conv;
            res[k].fin  = (k == 3);
        end
        for (int k = 0; k < 16; k++) work_m[k] = 0;
    endtask

    // offer one word in bursts with random gaps, then wait for acceptance
    task automatic send_word(logic [1:0] r, logic [1:0] c, logic signed [31:0] v,
                             logic lst, logic typed, logic signed [31:0] tev [4]);
        t_eig_word res [4];
        int        gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_row = r;
        i_col = c;
        i_entry_value = v;
        i_last = lst;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        jacobi_solve(r, c, v, lst, res);
        if (lst) begin
            for (int k = 0; k < 4; k++) begin
                if (typed) begin
                    res[k].eig = tev[k];
                    for (int q = 0; q < 4; q++) begin
                        res[k].vec[q] = (want_vec && q == k) ? 32'sh4000_0000 : 0;
                    end
                    res[k].rots = 0;
                    res[k].conv = 1'b1;
                end
                eig_q.push_back(res[k]);
            end
        end
    endtask

    // pause the sender until the solver has drained, then let it settle
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (eig_q.size() == 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_VECTORS: want_vec = data[0];
            CFG_MAX_ROT: rot_limit = int'(data);
            CFG_TOL:     tol_sh = int'(data[5:0]);
            default: ;
        endcase
    endtask

    // random entry value: mostly small, sometimes full range or zero
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 0;
            default: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
        endcase
    endfunction

    // random matrix, mostly symmetric pairs, some single or asymmetric entries
    task automatic send_matrix(inout int sent);
        logic signed [31:0] tev [4];
        logic signed [31:0] v;
        int                 n;
        logic [1:0]         r, c;
        n = $urandom_range(1, 5);
        for (int e = 0; e < n; e++) begin
            r = 2'($urandom());
            c = 2'($urandom());
            v = rand_value();
            if (r != c && $urandom_range(0, 9) != 0) begin
                send_word(r, c, v, 1'b0, 1'b0, tev);
                send_word(c, r, v, e == n - 1, 1'b0, tev);
                sent += 2;
            end else begin
                send_word(r, c, v, e == n - 1, 1'b0, tev);
                sent++;
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_eig_word     ex;
        logic signed [31:0] got_vec [4];
        if (i_rst_n && o_valid && !i_stall) begin
            got_vec = '{o_vec_0, o_vec_1, o_vec_2, o_vec_3};
            if (eig_q.size() == 0) begin
                $error("unexpected result word, eig_index %0d", o_eig_index);
                errors++;
            end else begin
                ex = eig_q.pop_front();
                if (o_eig_index !== ex.idx) begin
                    $error("eig_index exp %0d got %0d", ex.idx, o_eig_index);
                    errors++;
                end
                if (o_eigenvalue !== ex.eig) begin
                    $error("eigenvalue exp %h got %h", ex.eig, o_eigenvalue);
                    errors++;
                end
                for (int q = 0; q < 4; q++) begin
                    if (got_vec[q] !== ex.vec[q]) begin
                        $error("vec_%0d exp %h got %h", q, ex.vec[q], got_vec[q]);
                        errors++;
                    end
                end
                if (o_rotations_used !== ex.rots) begin
                    $error("rotations_used exp %0d got %0d", ex.rots, o_rotations_used);
                    errors++;
                end
                if (o_converged !== ex.conv) begin
                    $error("converged exp %0d got %0d", ex.conv, o_converged);
                    errors++;
                end
                if (o_last_result !== ex.fin) begin
                    $error("last_result exp %0d got %0d", ex.fin, o_last_result);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int mode_left, mode, held;
        i_stall = 1'b0;
        mode_left = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall = 1'b1;
                held = 1;
                while (held < HOLD_LEN) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    0: i_stall = 1'b0;
                    1: i_stall = ($urandom_range(0, 2) == 0);
                    default: i_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic signed [31:0] no_ev [4];
        int                 sent;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_row = '0;
        i_col = '0;
        i_entry_value = '0;
        i_last = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_VECTORS;
        i_cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        hold_req = 1'b0;
        no_ev = '{0, 0, 0, 0};
        want_vec = 1'b1;
        rot_limit = 100;
        tol_sh = 26;
        for (int k = 0; k < 16; k++) begin
            work_m[k] = 0;
            vect_m[k] = (k % 5 == 0) ? ONE_Q30 : 0;
        end

        // zero matrix straight after reset
        dir_tab[0]  = '{0, 0, 32'sh0, 1, 1, '{0, 0, 0, 0}};
        // diagonal extremes
        dir_tab[1]  = '{0, 0, 32'sh7FFF_FFFF, 0, 0, no_ev};
        dir_tab[2]  = '{1, 1, 32'sh8000_0000, 0, 0, no_ev};
        dir_tab[3]  = '{2, 2, 32'sh1, 0, 0, no_ev};
        dir_tab[4]  = '{3, 3, -32'sh1, 1, 1,
                        '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1, -32'sh1}};
        // equal diagonals, angle pi/4
        dir_tab[5]  = '{0, 0, 32'sh10000, 0, 0, no_ev};
        dir_tab[6]  = '{1, 1, 32'sh10000, 0, 0, no_ev};
        dir_tab[7]  = '{0, 1, 32'sh8000, 0, 0, no_ev};
        dir_tab[8]  = '{1, 0, 32'sh8000, 1, 0, no_ev};
        // asymmetric load
        dir_tab[9]  = '{0, 2, 32'sh20000, 0, 0, no_ev};
        dir_tab[10] = '{2, 0, -32'sh10000, 0, 0, no_ev};
        dir_tab[11] = '{2, 2, 32'sh30000, 1, 0, no_ev};
        // tied pivot magnitudes
        dir_tab[12] = '{0, 1, 32'sh1000, 0, 0, no_ev};
        dir_tab[13] = '{2, 3, 32'sh1000, 0, 0, no_ev};
        dir_tab[14] = '{3, 2, 32'sh1000, 0, 0, no_ev};
        dir_tab[15] = '{1, 0, 32'sh1000, 1, 0, no_ev};
        // extreme off-diagonals, saturation
        dir_tab[16] = '{0, 1, 32'sh7FFF_FFFF, 0, 0, no_ev};
        dir_tab[17] = '{1, 0, 32'sh7FFF_FFFF, 0, 0, no_ev};
        dir_tab[18] = '{2, 3, 32'sh8000_0000, 0, 0, no_ev};
        dir_tab[19] = '{3, 2, 32'sh8000_0000, 0, 0, no_ev};
        dir_tab[20] = '{3, 3, 32'sh8000_0000, 1, 0, no_ev};

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table under reset configuration
        for (int d = 0; d < DIR_N; d++) begin
            send_word(dir_tab[d].r, dir_tab[d].c, dir_tab[d].v, dir_tab[d].lst,
                      dir_tab[d].typed, dir_tab[d].ev);
        end
        drain_results();

        // random phases over several settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_VECTORS, 8'd0);
                    write_reg(CFG_MAX_ROT, 8'd0);
                    write_reg(CFG_TOL, 8'd40);
                end
                1: begin
                    write_reg(CFG_VECTORS, 8'd1);
                    write_reg(CFG_MAX_ROT, 8'd255);
                    write_reg(CFG_TOL, 8'd0);
                    hold_req = 1'b1;
                end
                2: begin
                    write_reg(CFG_MAX_ROT, 8'd10);
                    write_reg(CFG_TOL, 8'd20);
                end
                3: begin
                    write_reg(CFG_VECTORS, 8'd0);
                    write_reg(CFG_MAX_ROT, 8'd6);
                    write_reg(CFG_TOL, 8'd63);
                end
                default: begin
                    write_reg(CFG_VECTORS, 8'd1);
                    write_reg(CFG_MAX_ROT, 8'd16);
                    write_reg(CFG_TOL, 8'd12);
                end
            endcase
            sent = 0;
            while (sent < 25) send_matrix(sent);
            drain_results();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
